// File: hw/rtl/mkr_pkg.sv
// Shared types, constants and helpers for the multipole kick with radiation.
`default_nettype none
package mkr_pkg;

  localparam int TOP_ORDER = 3;
  localparam int NUM_COEF  = TOP_ORDER + 1;
  localparam int ONE_Q28   = 1 << 28;

  localparam int CFG_IW    = 3;
  localparam int QDEPTH    = 4;
  localparam int QPW       = $clog2(QDEPTH);

  localparam int DIV_LAT   = 33;
  localparam int SQ_LAT    = 29;
  localparam int SQ_VW     = 58;
  localparam int SQ_RW     = 29;

  localparam int FR_LAT    = 2 * TOP_ORDER + 2;
  localparam int BK_LAT    = 2 * DIV_LAT + SQ_LAT + 10;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [CFG_IW-1:0] {
    REG_COEF0,
    REG_COEF1,
    REG_COEF2,
    REG_COEF3,
    REG_LENGTH,
    REG_RADC
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] px;
    logic signed [31:0] y;
    logic signed [31:0] py;
    logic signed [31:0] dl;
  } particle_t;

  typedef struct packed {
    particle_t          p;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        onepd;
    logic               bad;
    logic signed [63:0] bxx;
    logic signed [63:0] byy;
    logic [63:0]        opd_sq;
    logic signed [64:0] lre;
    logic signed [64:0] lim;
  } kick_t;

  typedef struct packed {
    kick_t              k;
    logic signed [31:0] xp;
    logic signed [31:0] yp;
    logic signed [63:0] aux;
    logic               bad;
  } stage_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      return S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      return S32_MIN[31:0];
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mkr_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
`default_nettype none
module mkr_div import mkr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);

  logic [31:0] r   [DIV_LAT];
  logic [31:0] lo  [DIV_LAT];
  logic [31:0] d   [DIV_LAT];
  logic [31:0] q   [DIV_LAT];
  logic        ovf [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= num[63:32];
      lo[0]  <= num[31:0];
      d[0]   <= den;
      q[0]   <= '0;
      ovf[0] <= (num[63:32] >= den);
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
    logic [32:0] t;
    logic        ge;
    assign t  = {r[s-1], lo[s-1][31]};
    assign ge = (t >= {1'b0, d[s-1]});

    always_ff @(posedge clk) begin
      if (en) begin
        r[s]   <= ge ? 32'(t - {1'b0, d[s-1]}) : t[31:0];
        lo[s]  <= {lo[s-1][30:0], 1'b0};
        d[s]   <= d[s-1];
        q[s]   <= {q[s-1][30:0], ge};
        ovf[s] <= ovf[s-1];
      end
    end
  end

  assign quo = ovf[DIV_LAT-1] ? '1 : q[DIV_LAT-1];

endmodule
`default_nettype wire

// File: hw/rtl/mkr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module mkr_sqrt import mkr_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_VW-1:0] rad,
  output logic [SQ_RW-1:0] root
);

  logic [SQ_VW-1:0] rem [SQ_LAT];
  logic [SQ_VW-1:0] res [SQ_LAT];

  for (genvar g = 0; g < SQ_LAT; g++) begin : g_stage
    localparam logic [SQ_VW-1:0] BIT = SQ_VW'(1) << (2 * (SQ_LAT - 1 - g));
    logic [SQ_VW-1:0] rem_in;
    logic [SQ_VW-1:0] res_in;
    logic [SQ_VW-1:0] trial;

    if (g == 0) begin : g_first
      assign rem_in = rad;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem[g-1];
      assign res_in = res[g-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[g] <= rem_in - trial;
          res[g] <= (res_in >> 1) + BIT;
        end else begin
          rem[g] <= rem_in;
          res[g] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res[SQ_LAT-1][SQ_RW-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/mkr_front.sv
// Front end: accept particle words, evaluate the field polynomial, classify.
`default_nettype none
module mkr_front import mkr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           pos_x,
  input  logic signed [31:0]           mom_x,
  input  logic signed [31:0]           pos_y,
  input  logic signed [31:0]           mom_y,
  input  logic signed [31:0]           energy_dev,
  input  logic [NUM_COEF-1:0][63:0]    coef,
  input  logic [31:0]                  slice_length,
  input  logic                         q_full,
  output logic                         push,
  output kick_t                        push_data
);

  logic              en;
  logic [FR_LAT-1:0] fv;

  particle_t          hs_p  [TOP_ORDER+1];
  logic signed [31:0] hs_re [TOP_ORDER+1];
  logic signed [31:0] hs_im [TOP_ORDER+1];

  assign en       = !(fv[FR_LAT-1] && q_full);
  assign in_stall = !en;
  assign push     = fv[FR_LAT-1] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv <= {fv[FR_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hs_p[0]  <= '{x: pos_x, px: mom_x, y: pos_y, py: mom_y, dl: energy_dev};
      hs_re[0] <= coef[TOP_ORDER][63:32];
      hs_im[0] <= coef[TOP_ORDER][31:0];
    end
  end

  for (genvar k = 1; k <= TOP_ORDER; k++) begin : g_horner
    localparam int CI = TOP_ORDER - k;
    particle_t          mp;
    logic signed [63:0] rx, iy, ix, ry;
    logic signed [31:0] cb, ca;
    logic signed [63:0] nre, nim;

    assign cb  = coef[CI][63:32];
    assign ca  = coef[CI][31:0];
    assign nre = (rx >>> 28) - (iy >>> 28) + 64'(cb);
    assign nim = (ix >>> 28) + (ry >>> 28) + 64'(ca);

    always_ff @(posedge clk) begin
      if (en) begin
        mp       <= hs_p[k-1];
        rx       <= hs_re[k-1] * hs_p[k-1].x;
        iy       <= hs_im[k-1] * hs_p[k-1].y;
        ix       <= hs_im[k-1] * hs_p[k-1].x;
        ry       <= hs_re[k-1] * hs_p[k-1].y;
        hs_p[k]  <= mp;
        hs_re[k] <= sat32(nre);
        hs_im[k] <= sat32(nim);
      end
    end
  end

  logic signed [32:0] onepd_w;
  logic signed [32:0] len_s;

  assign onepd_w = 33'(hs_p[TOP_ORDER].dl) + 33'(ONE_Q28);
  assign len_s   = {1'b0, slice_length};

  always_ff @(posedge clk) begin
    if (en) begin
      push_data.p      <= hs_p[TOP_ORDER];
      push_data.re     <= hs_re[TOP_ORDER];
      push_data.im     <= hs_im[TOP_ORDER];
      push_data.onepd  <= onepd_w[31:0];
      push_data.bad    <= (onepd_w <= 33'sd0);
      push_data.bxx    <= hs_im[TOP_ORDER] * hs_im[TOP_ORDER];
      push_data.byy    <= hs_re[TOP_ORDER] * hs_re[TOP_ORDER];
      push_data.opd_sq <= onepd_w[31:0] * onepd_w[31:0];
      push_data.lre    <= len_s * hs_re[TOP_ORDER];
      push_data.lim    <= len_s * hs_im[TOP_ORDER];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/mkr_queue.sv
// Short queue between the front end and the back end.
`default_nettype none
module mkr_queue import mkr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  kick_t wdata,
  input  logic  pop,
  output kick_t rdata,
  output logic  full,
  output logic  empty
);

  kick_t          mem [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;

  assign full  = (count == (QPW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count lost a word");

endmodule
`default_nettype wire

// File: hw/rtl/mkr_back.sv
// Back end: angles, root, radiation loss, kick and output register.
`default_nettype none
module mkr_back import mkr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  kick_t              q_data,
  output logic               pop,
  input  logic [31:0]        slice_length,
  input  logic [31:0]        radiation_constant,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_mom_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_mom_y,
  output logic signed [31:0] out_energy_dev,
  output logic               invalid
);

  function automatic logic signed [31:0] to_angle(input logic [31:0] mag, input logic neg);
    if (neg) begin
      if (mag[31]) begin
        return 32'h8000_0000;
      end
      return 32'(-$signed({1'b0, mag}));
    end
    if (mag[31]) begin
      return 32'h7FFF_FFFF;
    end
    return mag;
  endfunction

  logic              en;
  logic [BK_LAT-1:0] vp;

  assign en        = !out_valid || !out_stall;
  assign pop       = en && !q_empty;
  assign out_valid = vp[BK_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[BK_LAT-2:0], !q_empty};
    end
  end

  // angles
  logic [32:0] ax, ay;
  logic [31:0] qx, qy;
  kick_t       dl1 [DIV_LAT];

  assign ax = q_data.p.px[31] ? (33'd0 - {q_data.p.px[31], q_data.p.px})
                              : {1'b0, q_data.p.px};
  assign ay = q_data.p.py[31] ? (33'd0 - {q_data.p.py[31], q_data.p.py})
                              : {1'b0, q_data.p.py};

  mkr_div u_div_x (.clk(clk), .en(en), .num({3'b0, ax, 28'b0}), .den(q_data.onepd), .quo(qx));
  mkr_div u_div_y (.clk(clk), .en(en), .num({3'b0, ay, 28'b0}), .den(q_data.onepd), .quo(qy));

  always_ff @(posedge clk) begin
    if (en) begin
      dl1[0] <= q_data;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl1[i] <= dl1[i-1];
      end
    end
  end

  kick_t              k1, k2, k3;
  logic signed [31:0] xp1, yp1, xp2, yp2, xp3, yp3;
  logic signed [63:0] pxx, pyy, pix, pry;
  logic [SQ_RW-1:0]   arg3;
  logic signed [31:0] dot3;
  logic               bad3;
  logic signed [63:0] arg_w;

  assign arg_w = 64'(ONE_Q28) - (pxx >>> 28) - (pyy >>> 28);

  always_ff @(posedge clk) begin
    if (en) begin
      k1   <= dl1[DIV_LAT-1];
      xp1  <= to_angle(qx, dl1[DIV_LAT-1].p.px[31]);
      yp1  <= to_angle(qy, dl1[DIV_LAT-1].p.py[31]);
      k2   <= k1;
      xp2  <= xp1;
      yp2  <= yp1;
      pxx  <= xp1 * xp1;
      pyy  <= yp1 * yp1;
      pix  <= k1.im * xp1;
      pry  <= k1.re * yp1;
      k3   <= k2;
      xp3  <= xp2;
      yp3  <= yp2;
      arg3 <= arg_w[SQ_RW-1:0];
      bad3 <= k2.bad || (arg_w <= 64'sd0);
      dot3 <= sat32((pix >>> 28) + (pry >>> 28));
    end
  end

  // root and path factor
  logic [SQ_RW-1:0]   root;
  logic signed [63:0] dd_w;
  stage_t             dl2 [SQ_LAT];
  stage_t             dl3 [DIV_LAT];
  stage_t             m5;
  logic signed [63:0] b2p_w;
  logic [31:0]        qq;

  assign dd_w = dot3 * dot3;

  mkr_sqrt u_sqrt (.clk(clk), .en(en), .rad({1'b0, arg3, 28'b0}), .root(root));

  assign m5    = dl2[SQ_LAT-1];
  assign b2p_w = (m5.k.bxx >>> 20) + (m5.k.byy >>> 20) - (m5.aux >>> 20);

  mkr_div u_div_q (
    .clk(clk),
    .en (en),
    .num({m5.k.opd_sq[63:28], 28'b0}),
    .den({3'b0, root}),
    .quo(qq)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl2[0] <= '{k: k3, xp: xp3, yp: yp3, aux: dd_w, bad: bad3};
      for (int i = 1; i < SQ_LAT; i++) begin
        dl2[i] <= dl2[i-1];
      end
      dl3[0] <= '{k: m5.k, xp: m5.xp, yp: m5.yp, aux: 64'(sat32(b2p_w)), bad: m5.bad};
      for (int i = 1; i < DIV_LAT; i++) begin
        dl3[i] <= dl3[i-1];
      end
    end
  end

  // loss and kick
  stage_t             s6, s7, s8, s9, s10, s11;
  logic [63:0]        fprod6;
  logic [31:0]        factor7;
  logic signed [31:0] b2p7;
  logic signed [32:0] fs7;
  logic signed [63:0] t1;
  logic [63:0]        m9;
  logic [63:0]        lr9, hr9;
  logic               neg9;
  logic [63:0]        mid;
  logic signed [63:0] loss_w;
  logic signed [63:0] nd_w;
  logic signed [31:0] nd10, nd11;
  logic signed [32:0] opn;
  logic signed [64:0] mx11, my11;
  logic signed [63:0] px_w, py_w;

  assign b2p7   = s7.aux[31:0];
  assign fs7    = {1'b0, factor7};
  assign m9     = t1[63] ? (64'd0 - t1) : t1;
  assign mid    = hr9 + (lr9 >> 32);
  assign loss_w = neg9 ? -$signed({32'd0, mid[63:32]}) : $signed({32'd0, mid[63:32]});
  assign nd_w   = 64'(s9.k.p.dl) - loss_w;
  assign opn    = 33'(nd10) + 33'(ONE_Q28);
  assign px_w   = 64'(mx11 >>> 28) - 64'(s11.k.lre >>> 16);
  assign py_w   = 64'(my11 >>> 28) + 64'(s11.k.lim >>> 16);

  always_ff @(posedge clk) begin
    if (en) begin
      s6      <= dl3[DIV_LAT-1];
      fprod6  <= slice_length * qq;
      s7      <= s6;
      factor7 <= (fprod6[63:60] != 4'd0) ? '1 : fprod6[59:28];
      s8      <= s7;
      t1      <= b2p7 * fs7;
      s9      <= s8;
      neg9    <= t1[63];
      lr9     <= m9[31:0] * radiation_constant;
      hr9     <= m9[63:32] * radiation_constant;
      s10     <= s9;
      nd10    <= sat32(nd_w);
      s11     <= s10;
      nd11    <= nd10;
      mx11    <= s10.xp * opn;
      my11    <= s10.yp * opn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x <= s11.k.p.x;
      out_pos_y <= s11.k.p.y;
      if (s11.bad) begin
        out_mom_x      <= s11.k.p.px;
        out_mom_y      <= s11.k.p.py;
        out_energy_dev <= s11.k.p.dl;
        invalid        <= 1'b1;
      end else begin
        out_mom_x      <= sat32(px_w);
        out_mom_y      <= sat32(py_w);
        out_energy_dev <= nd11;
        invalid        <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/multipole_kick_with_radiation.sv
// Top level: configuration registers, front end, queue and back end.
//
// Usage:
//   Input channel: one particle word (pos_x, mom_x, pos_y, mom_y, energy_dev)
//   is taken at each edge with in_valid high and in_stall low.
//   Output channel: one result word per particle, in order, delivered at an
//   edge with out_valid high and out_stall low.
//   Configuration: cfg_index selects coef_order0..3, slice_length or
//   radiation_constant; cfg_ready is always high. Write only while idle.
// Timing:
//   One particle per cycle sustained while the output is not stalled. The
//   latency is set by the two pipelined dividers in series (33 stages each)
//   and the root (29 stages).
// Reset:
//   Clears the configuration registers to zero and empties the pipelines and the queue.
// Stalls:
//   A stalled output freezes the back end; the queue then fills and in_stall
//   rises once it is full and the front end holds a finished word.
`default_nettype none
module multipole_kick_with_radiation import mkr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] mom_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] mom_y,
  input  logic signed [31:0] energy_dev,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_mom_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_mom_y,
  output logic signed [31:0] out_energy_dev,
  output logic               invalid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [NUM_COEF-1:0][63:0] coef;
  logic [31:0]               slice_length;
  logic [31:0]               radiation_constant;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef               <= '0;
      slice_length       <= '0;
      radiation_constant <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_COEF0:  coef[0]            <= cfg_data;
        REG_COEF1:  coef[1]            <= cfg_data;
        REG_COEF2:  coef[2]            <= cfg_data;
        REG_COEF3:  coef[3]            <= cfg_data;
        REG_LENGTH: slice_length       <= cfg_data[31:0];
        REG_RADC:   radiation_constant <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic  push, pop, q_full, q_empty;
  kick_t push_data, q_data;

  mkr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pos_x       (pos_x),
    .mom_x       (mom_x),
    .pos_y       (pos_y),
    .mom_y       (mom_y),
    .energy_dev  (energy_dev),
    .coef        (coef),
    .slice_length(slice_length),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  mkr_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(push_data),
    .pop  (pop),
    .rdata(q_data),
    .full (q_full),
    .empty(q_empty)
  );

  mkr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .pop               (pop),
    .slice_length      (slice_length),
    .radiation_constant(radiation_constant),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pos_x         (out_pos_x),
    .out_mom_x         (out_mom_x),
    .out_pos_y         (out_pos_y),
    .out_mom_y         (out_mom_y),
    .out_energy_dev    (out_energy_dev),
    .invalid           (invalid)
  );

endmodule
`default_nettype wire
